[hdl/stp_pkg.sv]
// Shared types, codes and character tables of the scan telegram parser.
package stp_pkg;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_DEV_ERR = "1";
    localparam logic [7:0] CHAR_CONTAM  = "4";

    localparam logic [4:0] TOK_HEADER = 5'd1;
    localparam logic [4:0] TOK_NAME   = 5'd2;
    localparam logic [4:0] TOK_DEVICE = 5'd6;
    localparam logic [4:0] TOK_DIST   = 5'd21;
    localparam logic [4:0] TOK_COUNT  = 5'd26;
    localparam logic [4:0] TOK_MAX    = 5'd31;

    localparam logic [3:0] POS_MAX        = 4'd15;
    localparam logic [3:0] MATCH_ALL      = 4'hF;
    localparam logic [3:0] LEN_HEADER_MIN = 4'd4;
    localparam logic [3:0] LEN_NAME       = 4'd11;
    localparam logic [3:0] LEN_DEVICE     = 4'd1;
    localparam logic [3:0] LEN_DIST       = 4'd5;

    localparam logic KIND_DIST   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic        REG_MAX_RANGE   = 1'b0;
    localparam logic [31:0] MAX_RANGE_RESET = 32'd20000;

    localparam int Q_DEPTH = 4;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_HEADER = 3'd1,
        ST_BAD_NAME   = 3'd2,
        ST_DEVICE_ERR = 3'd3,
        ST_CONTAM     = 3'd4,
        ST_NOT_DIST   = 3'd5,
        ST_TRUNC      = 3'd6
    } t_status;

    // Results caused by one byte: an optional distance, then an optional status.
    typedef struct packed {
        logic        has_dist;
        logic [15:0] dist_index;
        logic        has_stat;
        t_status     stat_code;
        logic [15:0] stat_index;
    } t_rec;

    function automatic logic [7:0] header_a_char(input logic [1:0] i);
        unique case (i)
            2'd0:    header_a_char = "s";
            2'd1:    header_a_char = "R";
            2'd2:    header_a_char = "A";
            default: header_a_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] header_b_char(input logic [1:0] i);
        unique case (i)
            2'd0:    header_b_char = "s";
            2'd1:    header_b_char = "S";
            2'd2:    header_b_char = "N";
            default: header_b_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] name_char(input logic [3:0] i);
        unique case (i)
            4'd0:    name_char = "L";
            4'd1:    name_char = "M";
            4'd2:    name_char = "D";
            4'd3:    name_char = "s";
            4'd4:    name_char = "c";
            4'd5:    name_char = "a";
            4'd6:    name_char = "n";
            4'd7:    name_char = "d";
            4'd8:    name_char = "a";
            4'd9:    name_char = "t";
            4'd10:   name_char = "a";
            default: name_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] dist_char(input logic [2:0] i);
        unique case (i)
            3'd0:    dist_char = "D";
            3'd1:    dist_char = "I";
            3'd2:    dist_char = "S";
            3'd3:    dist_char = "T";
            3'd4:    dist_char = "1";
            default: dist_char = 8'h00;
        endcase
    endfunction

    // Returns {valid, value} for one ASCII hex digit of either case.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        hex_digit = 5'd0;
        if (c >= "0" && c <= "9") begin
            d = c - 8'h30;
            hex_digit = {1'b1, d[3:0]};
        end else if (c >= "a" && c <= "f") begin
            d = c - 8'h57;
            hex_digit = {1'b1, d[3:0]};
        end else if (c >= "A" && c <= "F") begin
            d = c - 8'h37;
            hex_digit = {1'b1, d[3:0]};
        end
    endfunction

endpackage

[hdl/stp_front.sv]
// Front end: tokenizes the byte stream, checks the header tokens, parses hex.
module stp_front #(
    parameter int HEX_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  logic                i_frame_end,
    output logic                o_rec_valid,
    output stp_pkg::t_rec       o_rec,
    output logic [HEX_BITS-1:0] o_rec_acc
);
    import stp_pkg::*;

    localparam int CW = HEX_BITS + 1;

    logic [4:0]          r_tn, n_tn;
    logic [3:0]          r_pos, n_pos;
    logic                r_in_token, n_in_token;
    logic [3:0]          r_match, n_match;
    logic [HEX_BITS-1:0] r_acc, n_acc;
    logic                r_stop, n_stop;
    logic [15:0]         r_pc, n_pc;
    logic [15:0]         r_ps, n_ps;
    logic                r_in_data, n_in_data;
    t_status             r_err, n_err;

    logic                is_space, ignore, feed, start, do_end;
    logic                hex_ok;
    logic [3:0]          hex_val;
    logic [4:0]          tn_c;
    logic [3:0]          pos_b, pos_c, m_b, m_c;
    logic [HEX_BITS-1:0] acc_b, acc_c;
    logic                stp_b, stp_c;
    logic [CW-1:0]       acc_ext;
    logic [15:0]         count_sat;
    logic [3:0]          pos_m1;
    t_rec                rec;

    always_comb begin
        is_space = i_data_byte == CHAR_SPACE;
        ignore   = (r_err != ST_OK) || (r_tn >= TOK_COUNT && !r_in_data && !r_in_token);
        feed     = !ignore && !is_space;
        start    = feed && !r_in_token;
        do_end   = !ignore && (is_space ? r_in_token : i_frame_end);
        {hex_ok, hex_val} = hex_digit(i_data_byte);

        tn_c = r_tn;
        if (start && !r_in_data && r_tn < TOK_MAX) begin
            tn_c = r_tn + 5'd1;
        end
        pos_b = start ? 4'd0 : r_pos;
        m_b   = start ? MATCH_ALL : r_match;
        acc_b = start ? '0 : r_acc;
        stp_b = start ? 1'b0 : r_stop;
        pos_m1 = pos_b - 4'd1;

        pos_c = pos_b;
        m_c   = m_b;
        acc_c = acc_b;
        stp_c = stp_b;
        if (feed) begin
            unique case (tn_c)
                TOK_HEADER: begin
                    if (pos_b >= 4'd1 && pos_b <= 4'd3) begin
                        if (i_data_byte != header_a_char(pos_m1[1:0])) m_c[0] = 1'b0;
                        if (i_data_byte != header_b_char(pos_m1[1:0])) m_c[1] = 1'b0;
                    end
                end
                TOK_NAME: begin
                    if (pos_b < LEN_NAME && i_data_byte != name_char(pos_b)) m_c[0] = 1'b0;
                end
                TOK_DEVICE: begin
                    if (pos_b == 4'd0) begin
                        if (i_data_byte != CHAR_DEV_ERR) m_c[0] = 1'b0;
                        if (i_data_byte != CHAR_CONTAM) m_c[1] = 1'b0;
                    end
                end
                TOK_DIST: begin
                    if (pos_b < LEN_DIST && i_data_byte != dist_char(pos_b[2:0])) m_c[0] = 1'b0;
                end
                default: ;
            endcase

            if (!stp_b) begin
                if (!hex_ok) begin
                    stp_c = 1'b1;
                end else if (acc_b[HEX_BITS-1 -: 4] != 4'd0) begin
                    acc_c = '1;
                end else begin
                    acc_c = {acc_b[HEX_BITS-5:0], hex_val};
                end
            end
            pos_c = (pos_b == POS_MAX) ? POS_MAX : pos_b + 4'd1;
        end

        acc_ext   = CW'(acc_c);
        count_sat = (|acc_ext[CW-1:16]) ? 16'hFFFF : acc_ext[15:0];

        n_tn       = tn_c;
        n_pos      = pos_c;
        n_match    = m_c;
        n_acc      = acc_c;
        n_stop     = stp_c;
        n_in_token = do_end ? 1'b0 : (feed ? 1'b1 : r_in_token);
        n_err      = r_err;
        n_pc       = r_pc;
        n_ps       = r_ps;
        n_in_data  = r_in_data;

        rec = '0;
        rec.stat_code = ST_OK;

        if (do_end) begin
            if (r_in_data) begin
                rec.has_dist   = 1'b1;
                rec.dist_index = r_ps;
                n_ps = r_ps + 16'd1;
                if (n_ps == r_pc) n_in_data = 1'b0;
            end else begin
                unique case (tn_c)
                    TOK_HEADER: begin
                        if (!(pos_c >= LEN_HEADER_MIN && (|m_c[1:0]))) n_err = ST_BAD_HEADER;
                    end
                    TOK_NAME: begin
                        if (!(pos_c == LEN_NAME && m_c[0])) n_err = ST_BAD_NAME;
                    end
                    TOK_DEVICE: begin
                        if (pos_c == LEN_DEVICE && m_c[0]) n_err = ST_DEVICE_ERR;
                        else if (pos_c == LEN_DEVICE && m_c[1]) n_err = ST_CONTAM;
                    end
                    TOK_DIST: begin
                        if (!(pos_c == LEN_DIST && m_c[0])) n_err = ST_NOT_DIST;
                    end
                    TOK_COUNT: begin
                        n_pc      = count_sat;
                        n_ps      = 16'd0;
                        n_in_data = count_sat != 16'd0;
                    end
                    default: ;
                endcase
            end
        end

        if (i_frame_end) begin
            rec.has_stat   = 1'b1;
            rec.stat_index = n_ps;
            if (n_err != ST_OK) rec.stat_code = n_err;
            else if (n_in_data) rec.stat_code = ST_TRUNC;
            // return to the start-of-frame state
            n_tn       = 5'd0;
            n_pos      = 4'd0;
            n_in_token = 1'b0;
            n_match    = MATCH_ALL;
            n_acc      = '0;
            n_stop     = 1'b0;
            n_pc       = 16'd0;
            n_ps       = 16'd0;
            n_in_data  = 1'b0;
            n_err      = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tn       <= 5'd0;
            r_pos      <= 4'd0;
            r_in_token <= 1'b0;
            r_match    <= MATCH_ALL;
            r_acc      <= '0;
            r_stop     <= 1'b0;
            r_pc       <= 16'd0;
            r_ps       <= 16'd0;
            r_in_data  <= 1'b0;
            r_err      <= ST_OK;
        end else if (i_accept) begin
            r_tn       <= n_tn;
            r_pos      <= n_pos;
            r_in_token <= n_in_token;
            r_match    <= n_match;
            r_acc      <= n_acc;
            r_stop     <= n_stop;
            r_pc       <= n_pc;
            r_ps       <= n_ps;
            r_in_data  <= n_in_data;
            r_err      <= n_err;
        end
    end

    assign o_rec_valid = i_accept && (rec.has_dist || rec.has_stat);
    assign o_rec       = rec;
    assign o_rec_acc   = acc_c;

endmodule

[hdl/stp_queue.sv]
// Short FIFO of per-byte result records between front and back end.
module stp_queue #(
    parameter int HEX_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  stp_pkg::t_rec       i_rec,
    input  logic [HEX_BITS-1:0] i_acc,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output stp_pkg::t_rec       o_rec,
    output logic [HEX_BITS-1:0] o_acc
);
    import stp_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);

    t_rec                r_rec [Q_DEPTH];
    logic [HEX_BITS-1:0] r_acc [Q_DEPTH];
    logic [PW-1:0]       r_wr_ptr, r_rd_ptr;
    logic [PW:0]         r_count;
    logic                do_push, do_pop;

    assign o_full  = r_count == (PW+1)'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_rec   = r_rec[r_rd_ptr];
    assign o_acc   = r_acc[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_rec[r_wr_ptr] <= i_rec;
            r_acc[r_wr_ptr] <= i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + PW'(1);
            if (do_pop) r_rd_ptr <= r_rd_ptr + PW'(1);
            if (do_push && !do_pop) r_count <= r_count + (PW+1)'(1);
            else if (do_pop && !do_push) r_count <= r_count - (PW+1)'(1);
        end
    end

endmodule

[hdl/stp_back.sv]
// Back end: splits records into results, saturates and range-checks distances.
module stp_back #(
    parameter int HEX_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [31:0]         i_max_range,
    input  logic                i_q_valid,
    input  stp_pkg::t_rec       i_q_rec,
    input  logic [HEX_BITS-1:0] i_q_acc,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic                o_kind,
    output logic [15:0]         o_point_index,
    output logic [31:0]         o_distance_mm,
    output logic                o_in_range,
    output logic [2:0]          o_status,
    output logic                o_last
);
    import stp_pkg::*;

    localparam int EW = (HEX_BITS > 32) ? HEX_BITS : 33;

    logic                r_pend_v;
    t_rec                r_pend;
    logic [HEX_BITS-1:0] r_pend_acc;
    logic                r_dist_done;

    logic                r_out_v;
    logic                r_kind;
    logic [15:0]         r_index;
    logic [31:0]         r_dist;
    logic                r_in_range;
    t_status             r_status;
    logic                r_last;

    logic                out_free, load_out, emit_dist, consumed, pend_free;
    logic [EW-1:0]       acc_ext;
    logic                n_kind, n_in_range, n_last;
    logic [15:0]         n_index;
    logic [31:0]         n_dist;
    t_status             n_status;

    always_comb begin
        out_free  = !r_out_v || i_pop;
        emit_dist = r_pend.has_dist && !r_dist_done;
        load_out  = r_pend_v && out_free;
        consumed  = load_out && (!emit_dist || !r_pend.has_stat);
        pend_free = !r_pend_v || consumed;
        acc_ext   = EW'(r_pend_acc);

        if (emit_dist) begin
            n_kind     = KIND_DIST;
            n_index    = r_pend.dist_index;
            n_dist     = (|acc_ext[EW-1:32]) ? 32'hFFFF_FFFF : acc_ext[31:0];
            n_in_range = acc_ext <= EW'(i_max_range);
            n_status   = ST_OK;
            n_last     = !r_pend.has_stat;
        end else begin
            n_kind     = KIND_STATUS;
            n_index    = r_pend.stat_index;
            n_dist     = 32'd0;
            n_in_range = 1'b0;
            n_status   = r_pend.stat_code;
            n_last     = 1'b1;
        end
    end

    assign o_q_pop = i_q_valid && pend_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v    <= 1'b0;
            r_dist_done <= 1'b0;
        end else if (pend_free) begin
            r_pend_v    <= i_q_valid;
            r_dist_done <= 1'b0;
        end else if (load_out && emit_dist) begin
            // distance went out, status of the same byte still pending
            r_dist_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_free) begin
            r_pend     <= i_q_rec;
            r_pend_acc <= i_q_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (load_out) begin
            r_out_v <= 1'b1;
        end else if (i_pop) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_kind     <= n_kind;
            r_index    <= n_index;
            r_dist     <= n_dist;
            r_in_range <= n_in_range;
            r_status   <= n_status;
            r_last     <= n_last;
        end
    end

    assign o_empty       = !r_out_v;
    assign o_kind        = r_kind;
    assign o_point_index = r_index;
    assign o_distance_mm = r_dist;
    assign o_in_range    = r_in_range;
    assign o_status      = r_status;
    assign o_last        = r_last;

endmodule

[hdl/scan_telegram_parser.sv]
// Top level of the scan telegram parser: register port, front, queue and back.
//
// Input channel: one reply byte per transaction (push/full), frame_end on the
// last byte of a reply. Result channel (empty/pop): distance results as each
// data token completes, and one status result on the frame's last byte.
// Register port: APB-style, max_range_mm at byte address 0; pready is tied high.
//
// Throughput: one byte per cycle while full is low; the parser state updates on
// the accepting edge. A byte that ends a distance token together with the frame
// gives two results, which leave one after the other through the single output
// register. Results pass through the record queue and the pending record to it.
// A four-entry record queue between the parser and the result stage, plus one
// pending record and the output register, absorb receiver stalls; full rises
// only when all of them hold unread results.
// Reset (synchronous, active low) empties all queues, returns the parser to
// the start of a frame and loads max_range_mm with 20000.
module scan_telegram_parser #(
    parameter int HEX_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_end,
    output logic        empty,
    input  logic        pop,
    output logic        o_kind,
    output logic [15:0] o_point_index,
    output logic [31:0] o_distance_mm,
    output logic        o_in_range,
    output logic [2:0]  o_status,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import stp_pkg::*;

    logic [31:0]         r_max_range;
    logic                accept;
    logic                rec_valid, q_valid, q_pop;
    t_rec                rec, q_rec;
    logic [HEX_BITS-1:0] rec_acc, q_acc;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_RANGE) ? r_max_range : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_range <= MAX_RANGE_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_RANGE) begin
            r_max_range <= pwdata;
        end
    end

    assign accept = push && !full;

    stp_front #(.HEX_BITS(HEX_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_frame_end (i_frame_end),
        .o_rec_valid (rec_valid),
        .o_rec       (rec),
        .o_rec_acc   (rec_acc)
    );

    stp_queue #(.HEX_BITS(HEX_BITS)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_valid),
        .i_rec   (rec),
        .i_acc   (rec_acc),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rec   (q_rec),
        .o_acc   (q_acc)
    );

    stp_back #(.HEX_BITS(HEX_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_range   (r_max_range),
        .i_q_valid     (q_valid),
        .i_q_rec       (q_rec),
        .i_q_acc       (q_acc),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_kind        (o_kind),
        .o_point_index (o_point_index),
        .o_distance_mm (o_distance_mm),
        .o_in_range    (o_in_range),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule

[hdl/stp_checker.sv]
// Port-level checks of the scan telegram parser, bound to the top level.
module stp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic        o_kind,
    input logic [15:0] o_point_index,
    input logic [31:0] o_distance_mm,
    input logic        o_in_range,
    input logic [2:0]  o_status,
    input logic        o_last
);
    import stp_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable({o_kind, o_point_index, o_distance_mm,
                                    o_in_range, o_status, o_last}))
        else $error("stalled result changed");

    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_kind == KIND_STATUS |-> o_last && o_distance_mm == 32'd0 && !o_in_range)
        else $error("malformed status result");

    a_dist_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_kind == KIND_DIST |-> o_status == 3'(ST_OK))
        else $error("distance result carries a status code");

    a_status_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop && o_kind == KIND_DIST && !o_last |=> !empty && o_kind == KIND_STATUS)
        else $error("status of the same byte did not follow its distance");

endmodule

bind scan_telegram_parser stp_checker u_stp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_kind        (o_kind),
    .o_point_index (o_point_index),
    .o_distance_mm (o_distance_mm),
    .o_in_range    (o_in_range),
    .o_status      (o_status),
    .o_last        (o_last)
);
